// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the PI mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/qmpm_pkg.sv =====
// Package with types, widths, reset values and register codes of the PI mixer.
package qmpm_pkg;

	localparam int ANGLE_W = 12;
	localparam int POWER_W = 10;
	localparam int GAIN_W = 16;
	localparam int ERR_W = ANGLE_W + 1;
	localparam int PROD_W = ERR_W + GAIN_W + 1;
	localparam int SUM_W = PROD_W + 2;
	localparam int MIX_W = SUM_W + 2;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = GAIN_W;

	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int INTEGRAL_LIMIT_DEF = 250;

	localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(128);
	localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(3);
	localparam logic [POWER_W-1:0] POWER_LIMIT_RESET = POWER_W'(255);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ROLL_KP     = 3'd0,
		REG_ROLL_KI     = 3'd1,
		REG_PITCH_KP    = 3'd2,
		REG_PITCH_KI    = 3'd3,
		REG_YAW_KP      = 3'd4,
		REG_YAW_KI      = 3'd5,
		REG_POWER_LIMIT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
		logic enable_s2;
	} pi_ctl_t;

endpackage

// ===== rtl/qmpm_pi_axis.sv =====
// One PI controller: gain products, clamped integral and unshifted term.
`include "assert_macros.svh"

module qmpm_pi_axis #(
	parameter int GAIN_FRAC_BITS = qmpm_pkg::GAIN_FRAC_BITS_DEF,
	parameter int INTEGRAL_LIMIT = qmpm_pkg::INTEGRAL_LIMIT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qmpm_pkg::pi_ctl_t                      ctl,
	input  logic signed [qmpm_pkg::ANGLE_W-1:0]    target_s1,
	input  logic signed [qmpm_pkg::ANGLE_W-1:0]    current_s1,
	input  logic        [qmpm_pkg::GAIN_W-1:0]     kp,
	input  logic        [qmpm_pkg::GAIN_W-1:0]     ki,
	output logic signed [qmpm_pkg::SUM_W-1:0]      sum_s3
);

	localparam int LIMIT_VAL = INTEGRAL_LIMIT << GAIN_FRAC_BITS;
	localparam int INTEG_W = $clog2(LIMIT_VAL + 1) + 1;
	localparam int ACC_W = qmpm_pkg::PROD_W + 1;
	localparam logic signed [ACC_W-1:0] LIM_ACC = ACC_W'(LIMIT_VAL);
	localparam logic signed [INTEG_W-1:0] LIM_INT = INTEG_W'(LIMIT_VAL);

	logic signed [qmpm_pkg::ERR_W-1:0]  err;
	logic signed [qmpm_pkg::PROD_W-1:0] prod_kp_s2;
	logic signed [qmpm_pkg::PROD_W-1:0] prod_ki_s2;
	logic signed [INTEG_W-1:0]          integ_q;
	logic signed [ACC_W-1:0]            acc;
	logic signed [ACC_W-1:0]            acc_clamped;

	assign err = qmpm_pkg::ERR_W'(target_s1) - qmpm_pkg::ERR_W'(current_s1);

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_kp_s2 <= qmpm_pkg::PROD_W'(err * $signed({1'b0, kp}));
			prod_ki_s2 <= qmpm_pkg::PROD_W'(err * $signed({1'b0, ki}));
		end
	end

	always_comb begin
		acc = ACC_W'(integ_q) + ACC_W'(prod_ki_s2);
		if (acc > LIM_ACC) begin
			acc_clamped = LIM_ACC;
		end else if (acc < -LIM_ACC) begin
			acc_clamped = -LIM_ACC;
		end else begin
			acc_clamped = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctl.load_s3) begin
			if (ctl.enable_s2) begin
				integ_q <= INTEG_W'(acc_clamped);
			end else begin
				integ_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			sum_s3 <= qmpm_pkg::SUM_W'(prod_kp_s2) + qmpm_pkg::SUM_W'(acc_clamped);
		end
	end

	`ASSERT_ALWAYS(a_integ_in_range, clk, arst_n, (integ_q <= LIM_INT) && (integ_q >= -LIM_INT))
	`ASSERT_NEXT(a_integ_clear, clk, arst_n, ctl.load_s3 && !ctl.enable_s2, integ_q == '0)
	`ASSERT_NEXT(a_integ_hold, clk, arst_n, !ctl.load_s3, $stable(integ_q))

endmodule

// ===== rtl/qmpm_mixer.sv =====
// X-frame mixer: truncates the PI terms toward zero, mixes and clamps powers.
module qmpm_mixer #(
	parameter int GAIN_FRAC_BITS = qmpm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic signed [qmpm_pkg::SUM_W-1:0]   roll_sum,
	input  logic signed [qmpm_pkg::SUM_W-1:0]   pitch_sum,
	input  logic signed [qmpm_pkg::SUM_W-1:0]   yaw_sum,
	input  logic        [qmpm_pkg::POWER_W-1:0] base_power,
	input  logic                                enable,
	input  logic        [qmpm_pkg::POWER_W-1:0] power_limit,
	output logic        [qmpm_pkg::POWER_W-1:0] motor_one,
	output logic        [qmpm_pkg::POWER_W-1:0] motor_two,
	output logic        [qmpm_pkg::POWER_W-1:0] motor_three,
	output logic        [qmpm_pkg::POWER_W-1:0] motor_four
);

	localparam logic signed [qmpm_pkg::SUM_W-1:0] BIAS =
		qmpm_pkg::SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

	function automatic logic signed [qmpm_pkg::MIX_W-1:0] trunc_term(
		input logic signed [qmpm_pkg::SUM_W-1:0] v
	);
		logic signed [qmpm_pkg::SUM_W-1:0] biased;
		biased = v[qmpm_pkg::SUM_W-1] ? v + BIAS : v;
		return qmpm_pkg::MIX_W'(biased >>> GAIN_FRAC_BITS);
	endfunction

	function automatic logic [qmpm_pkg::POWER_W-1:0] clamp_power(
		input logic signed [qmpm_pkg::MIX_W-1:0] v,
		input logic        [qmpm_pkg::POWER_W-1:0] hs,
		input logic                                en
	);
		logic [qmpm_pkg::POWER_W-1:0] res;
		if (!en || v[qmpm_pkg::MIX_W-1]) begin
			res = '0;
		end else if (v > $signed({{(qmpm_pkg::MIX_W-qmpm_pkg::POWER_W){1'b0}}, hs})) begin
			res = hs;
		end else begin
			res = v[qmpm_pkg::POWER_W-1:0];
		end
		return res;
	endfunction

	logic signed [qmpm_pkg::MIX_W-1:0] r;
	logic signed [qmpm_pkg::MIX_W-1:0] p;
	logic signed [qmpm_pkg::MIX_W-1:0] y;
	logic signed [qmpm_pkg::MIX_W-1:0] b;

	assign r = trunc_term(roll_sum);
	assign p = trunc_term(pitch_sum);
	assign y = trunc_term(yaw_sum);
	assign b = $signed({{(qmpm_pkg::MIX_W-qmpm_pkg::POWER_W){1'b0}}, base_power});

	assign motor_one   = clamp_power(b + r - p - y, power_limit, enable);
	assign motor_two   = clamp_power(b + r + p - y, power_limit, enable);
	assign motor_three = clamp_power(b - r + p + y, power_limit, enable);
	assign motor_four  = clamp_power(b - r - p + y, power_limit, enable);

endmodule

// ===== rtl/quad_motor_pi_mixer.sv =====
// Top level of the quadcopter PI attitude controller with X-frame mixer.
//
// The block takes one control tick per clock cycle while the output is not
// stalled and returns one set of four motor powers per tick through its stages:
// an input register, a stage for the gain products, a stage that updates the
// clamped integrals, and the mixer feeding the output register. Each axis
// integral is updated in a single stage, which lets ticks follow one another in
// every cycle. Every stage holds its item while the next is full and stalled, so
// the input side keeps filling empty stages while a result waits at the output.
// The user writes gains and the power limit over the configuration port only
// while no tick is in flight (unenforced); there is no clearing pass after reset.
`include "assert_macros.svh"

module quad_motor_pi_mixer #(
	parameter int GAIN_FRAC_BITS = qmpm_pkg::GAIN_FRAC_BITS_DEF,
	parameter int INTEGRAL_LIMIT = qmpm_pkg::INTEGRAL_LIMIT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [qmpm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [qmpm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// target_roll, current_roll, target_pitch, current_pitch, target_yaw,
	// current_yaw, base_power, zero fill
	input  logic [87:0]                            s_axis_tdata,
	// enable
	input  logic [0:0]                             s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// motor_one, motor_two, motor_three, motor_four
	output logic [39:0]                            m_axis_tdata
);

	localparam int AW = qmpm_pkg::ANGLE_W;
	localparam int PW = qmpm_pkg::POWER_W;
	localparam int GW = qmpm_pkg::GAIN_W;

	logic [GW-1:0] roll_kp_q, roll_ki_q, pitch_kp_q, pitch_ki_q, yaw_kp_q, yaw_ki_q;
	logic [PW-1:0] power_limit_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;
	logic load_s1, load_s4;

	logic [6*AW-1:0] angles_s1;
	logic [PW-1:0]   base_s1, base_s2, base_s3;
	logic            enable_s1, enable_s2, enable_s3;

	qmpm_pkg::pi_ctl_t ctl;

	logic signed [qmpm_pkg::SUM_W-1:0] roll_sum_s3, pitch_sum_s3, yaw_sum_s3;
	logic [PW-1:0] m1, m2, m3, m4;
	logic [PW-1:0] motor_one_s4, motor_two_s4, motor_three_s4, motor_four_s4;
	logic          motors_in_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_kp_q     <= qmpm_pkg::KP_RESET;
			roll_ki_q     <= qmpm_pkg::KI_RESET;
			pitch_kp_q    <= qmpm_pkg::KP_RESET;
			pitch_ki_q    <= qmpm_pkg::KI_RESET;
			yaw_kp_q      <= qmpm_pkg::KP_RESET;
			yaw_ki_q      <= qmpm_pkg::KI_RESET;
			power_limit_q <= qmpm_pkg::POWER_LIMIT_RESET;
		end else if (cfg_we) begin
			case (qmpm_pkg::cfg_reg_t'(cfg_addr))
				qmpm_pkg::REG_ROLL_KP:     roll_kp_q     <= cfg_wdata[GW-1:0];
				qmpm_pkg::REG_ROLL_KI:     roll_ki_q     <= cfg_wdata[GW-1:0];
				qmpm_pkg::REG_PITCH_KP:    pitch_kp_q    <= cfg_wdata[GW-1:0];
				qmpm_pkg::REG_PITCH_KI:    pitch_ki_q    <= cfg_wdata[GW-1:0];
				qmpm_pkg::REG_YAW_KP:      yaw_kp_q      <= cfg_wdata[GW-1:0];
				qmpm_pkg::REG_YAW_KI:      yaw_ki_q      <= cfg_wdata[GW-1:0];
				qmpm_pkg::REG_POWER_LIMIT: power_limit_q <= cfg_wdata[PW-1:0];
				default: ;
			endcase
		end
	end

	assign ready4 = !valid_s4 || m_axis_tready;
	assign ready3 = !valid_s3 || ready4;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;
	assign s_axis_tready = ready1;

	assign load_s1 = s_axis_tvalid && ready1;
	assign ctl.load_s2 = valid_s1 && ready2;
	assign ctl.load_s3 = valid_s2 && ready3;
	assign ctl.enable_s2 = enable_s2;
	assign load_s4 = valid_s3 && ready4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			angles_s1 <= s_axis_tdata[6*AW-1:0];
			base_s1   <= s_axis_tdata[6*AW+PW-1:6*AW];
			enable_s1 <= s_axis_tuser[0];
		end
		if (ctl.load_s2) begin
			base_s2   <= base_s1;
			enable_s2 <= enable_s1;
		end
		if (ctl.load_s3) begin
			base_s3   <= base_s2;
			enable_s3 <= enable_s2;
		end
		if (load_s4) begin
			motor_one_s4   <= m1;
			motor_two_s4   <= m2;
			motor_three_s4 <= m3;
			motor_four_s4  <= m4;
		end
	end

	qmpm_pi_axis #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.INTEGRAL_LIMIT(INTEGRAL_LIMIT)
	) u_roll (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.target_s1  ($signed(angles_s1[AW-1:0])),
		.current_s1 ($signed(angles_s1[2*AW-1:AW])),
		.kp         (roll_kp_q),
		.ki         (roll_ki_q),
		.sum_s3     (roll_sum_s3)
	);

	qmpm_pi_axis #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.INTEGRAL_LIMIT(INTEGRAL_LIMIT)
	) u_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.target_s1  ($signed(angles_s1[3*AW-1:2*AW])),
		.current_s1 ($signed(angles_s1[4*AW-1:3*AW])),
		.kp         (pitch_kp_q),
		.ki         (pitch_ki_q),
		.sum_s3     (pitch_sum_s3)
	);

	qmpm_pi_axis #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.INTEGRAL_LIMIT(INTEGRAL_LIMIT)
	) u_yaw (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.target_s1  ($signed(angles_s1[5*AW-1:4*AW])),
		.current_s1 ($signed(angles_s1[6*AW-1:5*AW])),
		.kp         (yaw_kp_q),
		.ki         (yaw_ki_q),
		.sum_s3     (yaw_sum_s3)
	);

	qmpm_mixer #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_mixer (
		.roll_sum    (roll_sum_s3),
		.pitch_sum   (pitch_sum_s3),
		.yaw_sum     (yaw_sum_s3),
		.base_power  (base_s3),
		.enable      (enable_s3),
		.power_limit (power_limit_q),
		.motor_one   (m1),
		.motor_two   (m2),
		.motor_three (m3),
		.motor_four  (m4)
	);

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {motor_four_s4, motor_three_s4, motor_two_s4, motor_one_s4};

	assign motors_in_limit = (motor_one_s4 <= power_limit_q) &&
		(motor_two_s4 <= power_limit_q) &&
		(motor_three_s4 <= power_limit_q) &&
		(motor_four_s4 <= power_limit_q);

	`ASSERT_IMPLIES(a_out_limit, clk, arst_n, valid_s4, motors_in_limit)
	`ASSERT_NEXT(a_s3_holds, clk, arst_n, valid_s3 && !ready4, valid_s3 && $stable(roll_sum_s3))
	`ASSERT_IMPLIES(a_empty_ready, clk, arst_n, !valid_s1, s_axis_tready)

endmodule
